[rtl/core/mandel_pkg.sv]
// Shared widths, register indexes, controller states and control structs of the escape-time block.
package mandel_pkg;

	localparam int COORD_W   = 32;                       // Q4.28 coordinate
	localparam int FRAC_BITS = 28;
	localparam int COUNT_W   = 16;
	localparam int SCALE_W   = 17;                       // Q1.16, up to 1.0
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int PROD_W    = 2 * COORD_W;              // exact product, Q8.56
	localparam int MAG_W     = PROD_W - FRAC_BITS;       // |z|^2 after shift
	localparam int SUM_W     = PROD_W - FRAC_BITS + 2;   // shifted term plus c
	localparam int SCP_W     = COUNT_W + SCALE_W;        // count times scale

	localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(65536);

	localparam logic [COUNT_W-1:0]    MAX_ITER_RST = COUNT_W'(256);
	localparam logic [COORD_W-1:0]    ESCAPE_RST   = COORD_W'(1073741824);
	localparam logic [SCALE_W-1:0]    SCALE_RST    = SCALE_W'(256);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_ITER     = 3'd0,
		REG_ESCAPE_MAG2  = 3'd1,
		REG_COUNT_SCALE  = 3'd2,
		REG_START_REAL   = 3'd3,
		REG_START_IMAG   = 3'd4
	} cfg_reg_t;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RR   = 6'b000010,
		S_II   = 6'b000100,
		S_RI   = 6'b001000,
		S_UPD  = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;     // take c, reload z from z0, clear count
		logic sq_rr;    // multiplier: zr * zr
		logic sq_ii;    // multiplier: zi * zi, keep zr^2
		logic sq_ri;    // multiplier: zr * zi, form zr^2 - zi^2
		logic update;   // write new z, bump count
		logic finish;   // load output register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free; // output register can take a result this cycle
		logic escaped;  // |z|^2 not below threshold (valid in S_RI)
		logic limit;    // count after this iteration hits the limit (valid in S_UPD)
	} sts_t;

endpackage

[rtl/core/mandel_ctrl.sv]
// Sequencing state machine of the escape-time block.
module mandel_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  mandel_pkg::sts_t  sts,
	output mandel_pkg::cmd_t  cmd
);

	mandel_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mandel_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != mandel_pkg::S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			mandel_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = mandel_pkg::S_RR;
				end
			end
			mandel_pkg::S_RR: begin
				cmd.sq_rr = 1'b1;
				state_d   = mandel_pkg::S_II;
			end
			mandel_pkg::S_II: begin
				cmd.sq_ii = 1'b1;
				state_d   = mandel_pkg::S_RI;
			end
			mandel_pkg::S_RI: begin
				if (sts.escaped) begin
					state_d = mandel_pkg::S_FIN;
				end else begin
					cmd.sq_ri = 1'b1;
					state_d   = mandel_pkg::S_UPD;
				end
			end
			mandel_pkg::S_UPD: begin
				cmd.update = 1'b1;
				state_d    = sts.limit ? mandel_pkg::S_FIN : mandel_pkg::S_RR;
			end
			mandel_pkg::S_FIN: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = mandel_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mandel_pkg::S_IDLE;
			end
		endcase
	end

endmodule

[rtl/core/mandel_dp.sv]
// Datapath: config registers, shared multiplier, z update, escape test and output register.
module mandel_dp (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_wr_en,
	input  logic [mandel_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mandel_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
	input  logic signed [mandel_pkg::COORD_W-1:0]   c_real,
	input  logic signed [mandel_pkg::COORD_W-1:0]   c_imag,
	input  logic                                    out_stall,
	input  mandel_pkg::cmd_t                        cmd,
	output mandel_pkg::sts_t                        sts,
	output logic                                    out_valid,
	output logic [mandel_pkg::COUNT_W-1:0]          iterations,
	output logic [mandel_pkg::SCALE_W-1:0]          scaled_value
);

	localparam int CW = mandel_pkg::COORD_W;
	localparam int PW = mandel_pkg::PROD_W;
	localparam int FB = mandel_pkg::FRAC_BITS;
	localparam int SW = mandel_pkg::SUM_W;
	localparam int MW = mandel_pkg::MAG_W;

	localparam logic signed [SW-1:0] SAT_HI = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

	function automatic logic signed [CW-1:0] sat_coord(input logic signed [SW-1:0] v);
		logic signed [CW-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[CW-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[CW-1:0];
		end else begin
			r = v[CW-1:0];
		end
		return r;
	endfunction

	// config
	logic [mandel_pkg::COUNT_W-1:0] max_iter_q;
	logic [CW-1:0]                  escape_q;
	logic [mandel_pkg::SCALE_W-1:0] scale_q;
	logic signed [CW-1:0]           start_re_q, start_im_q;

	// iteration state
	logic signed [CW-1:0]           zr_q, zi_q, cr_q, ci_q;
	logic [mandel_pkg::COUNT_W-1:0] n_q;
	logic                           first_q;
	logic signed [PW-1:0]           p_q, rr_q, diff_q;
	logic                           out_valid_q;
	logic [mandel_pkg::COUNT_W-1:0] iter_out_q;
	logic [mandel_pkg::SCALE_W-1:0] scaled_out_q;

	logic signed [CW-1:0]           mul_a, mul_b;
	logic signed [PW-1:0]           mul_p;
	logic [PW-1:0]                  mag_sum;
	logic [MW-1:0]                  mag2;
	logic signed [SW-1:0]           re_sum, im_sum;
	logic [mandel_pkg::COUNT_W-1:0] n_inc;
	logic [mandel_pkg::SCP_W-1:0]   sc_prod;
	logic [mandel_pkg::SCALE_W-1:0] sc_sat;

	assign mul_a = cmd.sq_ii ? zi_q : zr_q;
	assign mul_b = cmd.sq_rr ? zr_q : zi_q;
	assign mul_p = mul_a * mul_b;

	// p_q holds zi^2 here; rr_q holds zr^2
	assign mag_sum = $unsigned(rr_q) + $unsigned(p_q);
	assign mag2    = mag_sum[PW-1:FB];

	// floor shifts are arithmetic right shifts of the exact products
	assign re_sum = {{(SW-(PW-FB)){diff_q[PW-1]}}, diff_q[PW-1:FB]}
	              + {{(SW-CW){cr_q[CW-1]}}, cr_q};
	assign im_sum = {{(SW-(PW-FB+1)){p_q[PW-1]}}, p_q[PW-1:FB-1]}
	              + {{(SW-CW){ci_q[CW-1]}}, ci_q};

	assign n_inc = n_q + 1'b1;

	assign sc_prod = mandel_pkg::SCP_W'(n_q) * mandel_pkg::SCP_W'(scale_q);
	assign sc_sat  = (sc_prod > mandel_pkg::SCP_W'(mandel_pkg::SCALE_ONE)) ?
	                 mandel_pkg::SCALE_ONE : sc_prod[mandel_pkg::SCALE_W-1:0];

	assign sts.out_free = !out_valid_q || !out_stall;
	assign sts.escaped  = !first_q && !(mag2 < {{(MW-CW){1'b0}}, escape_q});
	assign sts.limit    = (n_inc >= max_iter_q) || (n_inc == '1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q  <= mandel_pkg::MAX_ITER_RST;
			escape_q    <= mandel_pkg::ESCAPE_RST;
			scale_q     <= mandel_pkg::SCALE_RST;
			start_re_q  <= '0;
			start_im_q  <= '0;
			first_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					mandel_pkg::REG_MAX_ITER:
						max_iter_q <= cfg_wr_data[mandel_pkg::COUNT_W-1:0];
					mandel_pkg::REG_ESCAPE_MAG2:
						escape_q <= cfg_wr_data[CW-1:0];
					mandel_pkg::REG_COUNT_SCALE:
						scale_q <= cfg_wr_data[mandel_pkg::SCALE_W-1:0];
					mandel_pkg::REG_START_REAL:
						start_re_q <= cfg_wr_data[CW-1:0];
					mandel_pkg::REG_START_IMAG:
						start_im_q <= cfg_wr_data[CW-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.load) begin
				first_q <= 1'b1;
			end else if (cmd.update) begin
				first_q <= 1'b0;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			zr_q <= start_re_q;
			zi_q <= start_im_q;
			cr_q <= c_real;
			ci_q <= c_imag;
			n_q  <= '0;
		end
		if (cmd.sq_rr) begin
			p_q <= mul_p;
		end
		if (cmd.sq_ii) begin
			rr_q <= p_q;
			p_q  <= mul_p;
		end
		if (cmd.sq_ri) begin
			diff_q <= rr_q - p_q;
			p_q    <= mul_p;
		end
		if (cmd.update) begin
			zr_q <= sat_coord(re_sum);
			zi_q <= sat_coord(im_sum);
			n_q  <= n_inc;
		end
		if (cmd.finish) begin
			iter_out_q   <= n_q;
			scaled_out_q <= sc_sat;
		end
	end

	assign out_valid    = out_valid_q;
	assign iterations   = iter_out_q;
	assign scaled_value = scaled_out_q;

endmodule

[rtl/core/mandelbrot_escape_time.sv]
// Top level of the Mandelbrot escape-time unit: controller, datapath and checks.
//
// One point c (signed Q4.28) per input beat; z starts at the configured z0 and
// z = z*z + c is iterated until the count reaches max_iter (0 acts as 1) or
// |z|^2 is no longer below escape_mag2. One result beat per point: the count
// and the count times the scale factor, saturated to 1.0 in Q1.16. Points are
// worked one at a time. A single 32x32 multiplier is shared by zr^2, zi^2 and
// zr*zi, so each iteration steps through S_RR, S_II, S_RI and S_UPD; S_FIN
// waits until the output register is free. The result sits in an output
// register, and the next point is taken once the previous result has been
// placed there. Config writes go straight to the registers and are meant for
// idle periods only.
module mandelbrot_escape_time (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [mandel_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mandel_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [mandel_pkg::COORD_W-1:0] c_real,
	input  logic signed [mandel_pkg::COORD_W-1:0] c_imag,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [mandel_pkg::COUNT_W-1:0]        iterations,
	output logic [mandel_pkg::SCALE_W-1:0]        scaled_value
);

	mandel_pkg::cmd_t cmd;
	mandel_pkg::sts_t sts;

	// sequencer: one state per multiplier pass, then update and hand-off
	mandel_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// arithmetic, config registers and output register
	mandel_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wr_data  (cfg_wr_data),
		.c_real       (c_real),
		.c_imag       (c_imag),
		.out_stall    (out_stall),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.iterations   (iterations),
		.scaled_value (scaled_value)
	);

	// at most one datapath command per cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.sq_rr, cmd.sq_ii, cmd.sq_ri, cmd.update, cmd.finish}))
		else $error("more than one datapath command");

	// an accepted point blocks the input until its result is placed
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again while a point is in work");

	// the first iteration always runs
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (iterations != '0))
		else $error("result beat with zero iterations");

	// scaled value saturates at one
	a_scale_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (scaled_value <= mandel_pkg::SCALE_ONE))
		else $error("scaled value above 1.0");

endmodule

[dv/tb_mandelbrot_escape_time.sv]
// Self-checking testbench for the Mandelbrot escape-time unit: predictor, driver, monitor.
module tb_mandelbrot_escape_time;
	timeunit 1ns;
	timeprecision 1ps;
	import mandel_pkg::*;

	// One pixel point, as offered on the input channel
	typedef struct packed {
		logic signed [COORD_W-1:0] re;
		logic signed [COORD_W-1:0] im;
	} point_t;

	// One result beat
	typedef struct packed {
		logic [COUNT_W-1:0] iters;
		logic [SCALE_W-1:0] scaled;
	} escape_result_t;

	// Q4.28 landmarks
	localparam logic signed [COORD_W-1:0] Q_ONE     = 32'sh1000_0000;
	localparam logic signed [COORD_W-1:0] Q_QUARTER = 32'sh0400_0000;
	localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

	// Indexes past the last register; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam longint      COORD_HI  = 64'sd2147483647;
	localparam longint      COORD_LO  = -64'sd2147483648;
	localparam int unsigned COUNT_SAT = (1 << COUNT_W) - 1;

	localparam int LONG_HOLD          = 300;  // cycles the receiver sits on one result
	localparam int RANDOM_SETTINGS    = 12;
	localparam int POINTS_PER_SETTING = 108;

	logic                         clk         = 1'b0;
	logic                         arst_n      = 1'b0;
	logic                         cfg_wr_en   = 1'b0;
	logic [CFG_IDX_W-1:0]         cfg_index   = '0;
	logic [CFG_DATA_W-1:0]        cfg_wr_data = '0;
	logic                         in_valid    = 1'b0;
	logic                         in_stall;
	logic signed [COORD_W-1:0]    c_real      = '0;
	logic signed [COORD_W-1:0]    c_imag      = '0;
	logic                         out_valid;
	logic                         out_stall   = 1'b0;
	logic [COUNT_W-1:0]           iterations;
	logic [SCALE_W-1:0]           scaled_value;

	// Register image as the block should hold it
	logic [COUNT_W-1:0]           limit_cfg  = MAX_ITER_RST;
	logic [COORD_W-1:0]           escape_cfg = ESCAPE_RST;
	logic [SCALE_W-1:0]           scale_cfg  = SCALE_RST;
	logic signed [COORD_W-1:0]    z0_re_cfg  = '0;
	logic signed [COORD_W-1:0]    z0_im_cfg  = '0;

	point_t         points_to_send[$];    // waiting for the driver
	escape_result_t expected_results[$];  // one per accepted point, oldest first

	int          fail_count     = 0;
	int          results_checked = 0;
	int          early_escapes  = 0;
	int          stall_cycles   = 0;
	int          settings_used  = 1;      // reset values count as the first
	int unsigned send_idle_pct  = 17;
	int unsigned recv_idle_pct  = 55;
	bit          sender_paused  = 1'b0;
	int          holds_asked    = 0;
	int          holds_served;
	int          hold_left;

	mandelbrot_escape_time dut (
		.clk,
		.arst_n,
		.cfg_wr_en,
		.cfg_index,
		.cfg_wr_data,
		.in_valid,
		.in_stall,
		.c_real,
		.c_imag,
		.out_valid,
		.out_stall,
		.iterations,
		.scaled_value
	);

	initial forever #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic longint clamp_coord(input longint v);
		if (v > COORD_HI)
			return COORD_HI;
		if (v < COORD_LO)
			return COORD_LO;
		return v;
	endfunction

	// Escape-time count for one point under the current register image.
	// Products are exact in 64 bits (Q8.56); >>> on a signed value floors,
	// which is the rounding the block uses. The squared magnitude can reach
	// 2^63 before the shift, so it is summed unsigned.
	function automatic escape_result_t escape_time(input logic signed [COORD_W-1:0] cr,
			input logic signed [COORD_W-1:0] ci);
		longint            zr, zi, rr, ii, ri, c_re, c_im;
		longint unsigned   mag_re, mag_im, mag2, product;
		int unsigned       n;
		escape_result_t    res;
		c_re = cr;
		c_im = ci;
		zr   = z0_re_cfg;
		zi   = z0_im_cfg;
		n    = 0;
		forever begin
			rr = zr * zr;
			ii = zi * zi;
			ri = zr * zi;
			zr = clamp_coord(((rr - ii) >>> FRAC_BITS) + c_re);
			zi = clamp_coord((ri >>> (FRAC_BITS - 1)) + c_im);
			if (n < COUNT_SAT)
				n++;
			// a limit of zero stops after the first pass, same as one
			if (n >= limit_cfg || n >= COUNT_SAT)
				break;
			mag_re = zr * zr;
			mag_im = zi * zi;
			mag2   = (mag_re + mag_im) >> FRAC_BITS;
			if (mag2 >= escape_cfg)
				break;
		end
		product    = longint'(n) * scale_cfg;
		res.iters  = n[COUNT_W-1:0];
		res.scaled = (product > SCALE_ONE) ? SCALE_ONE : product[SCALE_W-1:0];
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Register writes and stimulus helpers
	// ------------------------------------------------------------------

	// One write beat; the register image follows with the same masking
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_index   <= idx;
		cfg_wr_data <= data;
		case (idx)
			REG_MAX_ITER:     limit_cfg  = data[COUNT_W-1:0];
			REG_ESCAPE_MAG2:  escape_cfg = data[COORD_W-1:0];
			REG_COUNT_SCALE:  scale_cfg  = data[SCALE_W-1:0];
			REG_START_REAL:   z0_re_cfg  = data[COORD_W-1:0];
			REG_START_IMAG:   z0_im_cfg  = data[COORD_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic apply_setting(input logic [CFG_DATA_W-1:0] lim_word, esc_word, scl_word,
			zr_word, zi_word);
		write_reg(REG_MAX_ITER, lim_word);
		write_reg(REG_ESCAPE_MAG2, esc_word);
		write_reg(REG_COUNT_SCALE, scl_word);
		write_reg(REG_START_REAL, zr_word);
		write_reg(REG_START_IMAG, zi_word);
		settings_used++;
		@(negedge clk);
	endtask

	// Every result beat is back and the input side is quiet. Each point gives a
	// result, so nothing is left in flight once the queue of expectations drains.
	task automatic wait_idle();
		while (points_to_send.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic queue_point(input logic signed [COORD_W-1:0] re, im);
		point_t pt;
		pt.re = re;
		pt.im = im;
		points_to_send.push_back(pt);
	endtask

	function automatic logic signed [COORD_W-1:0] edge_coord();
		case ($urandom_range(5))
			0:       return COORD_MIN;
			1:       return COORD_MAX;
			2:       return '0;
			3:       return -32'sd1;
			4:       return 32'sd1;
			default: return -(2 * Q_ONE);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Input driver: a new beat only once the current one has gone
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : send_points
		point_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (points_to_send.size() != 0 && !sender_paused
					&& $urandom_range(99) >= send_idle_pct) begin
				nxt = points_to_send.pop_front();
				in_valid <= 1'b1;
				c_real   <= nxt.re;
				c_imag   <= nxt.im;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result side back-pressure. A long hold is asked for by bumping
	// holds_asked; the count-down lives here.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall    <= 1'b0;
			hold_left    <= 0;
			holds_served <= 0;
		end else if (holds_served != holds_asked) begin
			holds_served <= holds_asked;
			hold_left    <= LONG_HOLD;
			out_stall    <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predict on each input beat, check each result beat
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch
		escape_result_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_results.push_back(escape_time(c_real, c_imag));
			if (in_valid && in_stall)
				stall_cycles++;
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result beat with nothing outstanding: iterations %0d scaled %0d",
							$time, iterations, scaled_value);
				end else begin
					want = expected_results.pop_front();
					results_checked++;
					if (want.iters < limit_cfg && want.iters < COUNT_SAT)
						early_escapes++;
					if (iterations !== want.iters || scaled_value !== want.scaled) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: mismatch: iterations exp %0d got %0d, scaled exp %0d got %0d",
								$time, want.iters, iterations, want.scaled, scaled_value);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		logic [COUNT_W-1:0]        lim;
		logic [CFG_DATA_W-1:0]     esc;
		logic [CFG_DATA_W-1:0]     scl;
		logic signed [COORD_W-1:0] zr0;
		logic signed [COORD_W-1:0] zi0;
		int unsigned               pick;
		point_t                    pt;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset values: limit 256, escape at 4.0, scale 1/256, z0 at the origin.
		queue_point('0, '0);                          // in the set, runs to the limit
		queue_point(-(2 * Q_ONE), '0);                // |z|^2 lands exactly on 4.0
		queue_point(Q_QUARTER, '0);                   // cusp, slow convergence
		queue_point(-32'sh0C00_0000, 32'sh0199_999A); // -0.75 + 0.1i, neck region
		queue_point(32'sh04CC_CCCD, 32'sh0800_0000);  // 0.3 + 0.5i
		queue_point(-Q_ONE, '0);                      // period-two orbit
		queue_point('0, Q_ONE);                       // orbit through i, -1+i, -i
		queue_point(COORD_MIN, COORD_MIN);            // corners: coordinates saturate
		queue_point(COORD_MAX, COORD_MAX);
		queue_point(COORD_MAX, COORD_MIN);
		queue_point(COORD_MIN, COORD_MAX);
		queue_point('0, COORD_MIN);
		queue_point(COORD_MAX, '0);
		queue_point(-32'sd1, 32'sd1);                 // one LSB either side of zero
		wait_idle();

		// Limit of zero, widest threshold, scale above 1.0 (all seventeen bits
		// set) and z0 at opposite corners; junk above the limit and scale widths.
		apply_setting(32'hA5A5_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, COORD_MAX, COORD_MIN);
		// writes past the last register must not land anywhere
		write_reg(REG_SPARE_LO, 32'h0000_0010);
		write_reg(REG_SPARE_HI, 32'h0000_0003);
		@(negedge clk);
		queue_point('0, '0);
		queue_point(COORD_MIN, COORD_MAX);
		queue_point(32'sd1, '0);
		queue_point(COORD_MAX, COORD_MAX);
		wait_idle();

		// Short limit with the scale at exactly 1.0: the product saturates
		apply_setting(32'hFFFF_0003, ESCAPE_RST, {15'h7FFF, SCALE_ONE}, '0, '0);
		queue_point('0, '0);
		queue_point(-(2 * Q_ONE), '0);
		queue_point(COORD_MIN, COORD_MIN);
		queue_point(32'sd1, 32'sd1);
		wait_idle();

		// Largest limit: one point runs the count all the way to saturation
		apply_setting(32'h0000_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, '0, '0);
		queue_point('0, '0);
		queue_point(Q_ONE, Q_ONE);
		queue_point(COORD_MAX, COORD_MAX);

		// Random settings, each with a batch of random points. Extremes of each
		// register are pinned to particular batches, the rest drawn at random.
		for (int p = 0; p < RANDOM_SETTINGS; p++) begin
			wait_idle();

			lim = (p == 0) ? 16'd1 : (p == 3) ? 16'd0 : 16'($urandom_range(2, 40));

			if (p == 2)
				esc = '0;                        // escape on the first test
			else if (p == 5)
				esc = '1;
			else if ($urandom_range(1))
				esc = ESCAPE_RST;
			else
				esc = $urandom;

			if (p == 1)
				scl = '0;
			else if (p == 4)
				scl = {15'($urandom), SCALE_ONE};
			else if (p == 7)
				scl = 32'h0001_FFFF;
			else if ($urandom_range(1))
				scl = {15'($urandom), 17'(65536 / ((lim == 0) ? 1 : lim))};
			else
				scl = $urandom;

			if (p == 9) begin
				zr0 = COORD_MIN;
				zi0 = COORD_MAX;
			end else if (p == 10) begin
				zr0 = COORD_MAX;
				zi0 = COORD_MIN;
			end else if ($urandom_range(1)) begin
				zr0 = '0;
				zi0 = '0;
			end else begin
				zr0 = int'($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000;
				zi0 = int'($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000;
			end

			apply_setting({16'($urandom), lim}, esc, scl, zr0, zi0);

			// idling: sender light / receiver heavy, then swapped, then none
			if (p == 4) begin
				send_idle_pct = 55;
				recv_idle_pct = 17;
			end
			if (p == 8) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				holds_asked++;   // receiver sits still while points keep coming
			end

			for (int k = 0; k < POINTS_PER_SETTING; k++) begin
				pick = $urandom_range(99);
				if (pick < 55) begin
					// the usual viewing window, -2.25..0.75 by -1.5..1.5
					pt.re = int'($urandom_range(0, 32'h3000_0000)) - 32'sh2400_0000;
					pt.im = int'($urandom_range(0, 32'h3000_0000)) - 32'sh1800_0000;
				end else if (pick < 70) begin
					// near the origin: mostly inside, so the limit is reached
					pt.re = int'($urandom_range(0, 32'h0800_0000)) - Q_QUARTER;
					pt.im = int'($urandom_range(0, 32'h0800_0000)) - Q_QUARTER;
				end else if (pick < 80) begin
					pt.re = edge_coord();
					pt.im = edge_coord();
				end else begin
					pt.re = $urandom;
					pt.im = $urandom;
				end
				points_to_send.push_back(pt);
			end

			// halfway through one batch the sender waits for a full drain
			if (p == 5) begin
				while (points_to_send.size() > POINTS_PER_SETTING / 2)
					@(negedge clk);
				sender_paused = 1'b1;
				while (in_valid || expected_results.size() != 0)
					@(negedge clk);
				sender_paused = 1'b0;
			end
		end

		while (points_to_send.size() != 0 || in_valid)
			@(negedge clk);
		while (expected_results.size() != 0)
			@(negedge clk);
		// a stray late beat would show up here
		repeat (20) @(negedge clk);

		$display("%0d points checked over %0d register settings, %0d of them escaped early",
			results_checked, settings_used, early_escapes);
		$display("input held off for %0d cycles; %0d mismatches", stall_cycles, fail_count);
		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("mandelbrot_escape_time regression: pass");
		end else begin
			$display("mandelbrot_escape_time regression: fail");
		end
		$finish;
	end

	// The 65535-iteration point is the longest part of the slowest correct run;
	// a run still going at 30 ms is failed.
	initial begin
		#30_000_000;
		$display("mandelbrot_escape_time regression: fail");
		$finish;
	end

endmodule
